// ===== rtl/pipelined_prime_sieve_defines.svh =====
// Assertion macros for the pipelined prime sieve.
// Used by the top level only; each macro expects clk and rst_n in scope.
`ifndef PIPELINED_PRIME_SIEVE_DEFINES_SVH
`define PIPELINED_PRIME_SIEVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pipelined_prime_sieve: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pipelined_prime_sieve: assertion failed");

`endif

// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the pipelined prime sieve.
// No dependencies; imported by both RTL modules and both test files.
package pps_pkg;

    localparam int NUM_CELLS  = 32;
    localparam int VALUE_BITS = 16;
    localparam int STEP_BITS  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [1:0]            status_t;

    // Input beat kinds.
    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_END    = 1'b1;

    // Result status codes.
    localparam status_t STAT_PRIME = 2'd0;
    localparam status_t STAT_END   = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

    // Control broadcast from the sequencer to every cell in the row.
    typedef struct packed {
        logic start;        // clear the partial remainder
        logic step;         // one restoring division step
        logic dividend_bit; // next dividend bit, most significant first
        logic shift;        // take value and fill flag from the neighbour
        logic clear;        // empty the cell
    } cell_ctrl_t;

endpackage

// ===== rtl/pps_cell.sv =====
// One sieve cell: holds a stored prime and divides the current candidate by it.
// Depends on pps_pkg for the value and control types.
module pps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pps_pkg::cell_ctrl_t ctrl,
    input  pps_pkg::value_t     prev_value,
    input  logic                prev_used,
    output pps_pkg::value_t     value,
    output logic                used,
    output logic                hit
);
    import pps_pkg::*;

    value_t              prime_reg;
    value_t              rem_reg;
    logic                used_reg;
    logic [VALUE_BITS:0] trial;
    logic [VALUE_BITS:0] diff;

    // Restoring division step: shift in a dividend bit, subtract if it fits.
    assign trial = {rem_reg, ctrl.dividend_bit};
    assign diff  = trial - {1'b0, prime_reg};

    // Stored prime moves along the row when a new prime enters at the head.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prime_reg <= prev_value;
        end
    end

    // Fill flag follows the stored prime and is dropped at end of stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            used_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            used_reg <= prev_used;
        end
    end

    // Partial remainder; a zero divisor leaves the dividend in place.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (diff[VALUE_BITS])
            begin
                rem_reg <= trial[VALUE_BITS-1:0];
            end
            else
            begin
                rem_reg <= diff[VALUE_BITS-1:0];
            end
        end
    end

    assign value = prime_reg;
    assign used  = used_reg;
    assign hit   = used_reg && (prime_reg != '0) && (rem_reg == '0);

endmodule

// ===== rtl/pipelined_prime_sieve.sv =====
// Top level of the pipelined prime sieve: sequencer, output register, cell row.
// Depends on pps_pkg, pps_cell and pipelined_prime_sieve_defines.svh.
//
//   Channel  Signals                                Direction
//   in       in_valid in_ready kind candidate        into the block
//   out      out_valid out_ready status prime_value  out of the block
//
// A candidate takes one restoring division step per value bit, run in every
// cell at once, then a decision state combines the cell flags, registers the
// result and shifts a new prime into the row; the next beat is taken once the
// sequencer is back in idle. An end beat goes straight to the decision state.
// Reset empties the row at once. A waiting result does not block the next
// input beat; a stalled output only holds the block once a second result is ready.
`include "pipelined_prime_sieve_defines.svh"

module pipelined_prime_sieve (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [15:0]      candidate,
    output logic             out_valid,
    input  logic             out_ready,
    output pps_pkg::status_t status,
    output logic [15:0]      prime_value
);
    import pps_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [STEP_BITS-1:0] step_reg;
    value_t               cand_reg;
    value_t               dvd_reg;
    logic                 end_reg;
    logic                 out_valid_reg;
    status_t              status_reg;
    value_t               prime_value_reg;

    cell_ctrl_t           ctrl;
    value_t               cell_value [NUM_CELLS];
    logic [NUM_CELLS-1:0] used_vec;
    logic [NUM_CELLS-1:0] hit_vec;

    logic accept;
    logic out_free;
    logic any_hit;
    logic row_full;
    logic emit;
    logic finish;
    logic last_step;

    // Handshake and decision terms.
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign any_hit   = |hit_vec;
    assign row_full  = used_vec[NUM_CELLS-1];
    assign emit      = end_reg || !any_hit;
    assign finish    = (state_reg == S_DONE) && (!emit || out_free);
    assign last_step = (step_reg == STEP_BITS'(VALUE_BITS - 1));

    // Control broadcast to the row.
    always_comb
    begin
        ctrl.start        = accept;
        ctrl.step         = (state_reg == S_RUN);
        ctrl.dividend_bit = dvd_reg[VALUE_BITS-1];
        ctrl.shift        = finish && !end_reg && !any_hit && !row_full;
        ctrl.clear        = finish && end_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind == KIND_END) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_RUN)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Captured beat and the dividend shifter, most significant bit first.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg <= candidate[VALUE_BITS-1:0];
            dvd_reg  <= candidate[VALUE_BITS-1:0];
            end_reg  <= kind;
        end
        else if (state_reg == S_RUN)
        begin
            dvd_reg <= {dvd_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish && emit)
        begin
            if (end_reg)
            begin
                status_reg      <= STAT_END;
                prime_value_reg <= '0;
            end
            else
            begin
                status_reg      <= row_full ? STAT_FULL : STAT_PRIME;
                prime_value_reg <= cand_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign prime_value = 16'(prime_value_reg);

    // Row of cells; a new prime enters at cell zero and the row shifts.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        value_t prev_value;
        logic   prev_used;

        if (i == 0)
        begin : g_head
            assign prev_value = cand_reg;
            assign prev_used  = 1'b1;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_used  = used_vec[i-1];
        end

        pps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_value (prev_value),
            .prev_used  (prev_used),
            .value      (cell_value[i]),
            .used       (used_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    // The row always fills from cell zero without gaps.
    `PPS_ASSERT_NOW(a_row_packed, 1'b1, ((used_vec & (used_vec >> 1)) == (used_vec >> 1)))
    // A result only appears after the decision cycle.
    `PPS_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg), ($past(state_reg) == S_DONE))
    // A candidate beat starts the division run, an end beat goes straight to the decision.
    `PPS_ASSERT_NEXT(a_beat_routing, accept, ((state_reg == S_RUN) != end_reg))
    // A full row is never shifted.
    `PPS_ASSERT_NOW(a_no_shift_full, ctrl.shift, !row_full)

endmodule

// ===== test/pipelined_prime_sieve_checker.sv =====
// Scoreboard for the pipelined prime sieve: watches both channels, predicts each result
// beat from the input beats and compares it field by field with what the block emits.
// Depends on pps_pkg for the status codes, the value type and the row size.
`timescale 1ns / 100ps

module pipelined_prime_sieve_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             kind,
    input  logic [15:0]      candidate,
    input  logic             out_valid,
    input  logic             out_ready,
    input  pps_pkg::status_t status,
    input  logic [15:0]      prime_value,
    output int               fail_count,
    output int               outstanding
);

    import pps_pkg::*;

    typedef struct {
        status_t code;
        value_t  prime;
    } sieve_result_t;

    // Own copy of the prime row and the queue of results still to come out.
    value_t        prime_row [NUM_CELLS];
    int            row_fill;
    sieve_result_t awaited_results [$];
    int            fails   = 0;
    int            waiting = 0;

    assign fail_count  = fails;
    assign outstanding = waiting;

    // Work out what one accepted input beat should produce.
    function automatic void sieve_predict(input logic item_kind, input value_t number);
        logic          divided;
        sieve_result_t res;
        divided = 1'b0;
        if (item_kind == KIND_END)
        begin
            row_fill  = 0;
            res.code  = STAT_END;
            res.prime = '0;
            awaited_results.push_back(res);
            return;
        end
        // A stored zero divides nothing, as a divider by zero returns the dividend.
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (i < row_fill && prime_row[i] != '0 && (number % prime_row[i]) == '0)
                divided = 1'b1;
        end
        if (divided)
            return;
        if (row_fill < NUM_CELLS)
        begin
            prime_row[row_fill] = number;
            row_fill++;
            res.code = STAT_PRIME;
        end
        else
        begin
            res.code = STAT_FULL;
        end
        res.prime = number;
        awaited_results.push_back(res);
    endfunction

    // Compare one result beat with the oldest prediction.
    function automatic void compare_result();
        sieve_result_t exp_res;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result beat, status %0d value %0d",
                     $realtime, status, prime_value);
            fails++;
            return;
        end
        exp_res = awaited_results.pop_front();
        if (status !== exp_res.code)
        begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, exp_res.code, status);
            fails++;
        end
        if (prime_value !== exp_res.prime)
        begin
            $display("%0t: prime_value mismatch, expected %0d actual %0d",
                     $realtime, exp_res.prime, prime_value);
            fails++;
        end
    endfunction

    // Results go first: a beat accepted at this edge cannot have produced one yet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            row_fill = 0;
            waiting  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_result();
            if (in_valid && in_ready)
                sieve_predict(kind, value_t'(candidate));
            waiting = awaited_results.size();
        end
    end

endmodule

// ===== test/pipelined_prime_sieve_tb.sv =====
// Testbench top for the pipelined prime sieve: clock, reset, input stimulus, output stalls,
// watchdog and verdict. Depends on pps_pkg, the block itself and pipelined_prime_sieve_checker.
`timescale 1ns / 100ps

module pipelined_prime_sieve_tb;

    import pps_pkg::*;

    localparam int   TARGET_BEATS  = 1650;
    localparam int   IDLE_LIMIT    = 3000;
    localparam int   LATENCY       = VALUE_BITS + 2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        kind      = KIND_NUMBER;
    logic [15:0] candidate = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    status_t     status;
    logic [15:0] prime_value;
    int          fail_count;
    int          outstanding;

    int          beats_sent = 0;
    int          burst_left = 0;
    logic        steady     = 1'b0;
    int          idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pipelined_prime_sieve u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .prime_value (prime_value)
    );

    pipelined_prime_sieve_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .prime_value (prime_value),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Send one beat in bursts with random gaps; called and returning at a falling edge.
    task automatic send_beat(input logic item_kind, input logic [15:0] number);
        if (burst_left == 0)
        begin
            if (!steady)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid  <= 1'b1;
        kind      <= item_kind;
        candidate <= number;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    // Noise values lean on the corners of the candidate range.
    function automatic logic [15:0] noise_value();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // The receiver picks a new stall pattern each time the stall phase wraps.
    int stall_mode  = 0;
    int stall_phase = 0;
    always @(negedge clk)
    begin
        if (stall_phase == 0)
            stall_mode = $urandom_range(0, 3);
        stall_phase = (stall_phase + 1) % 200;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((stall_phase % 5) < 2);
        endcase
    end

    // Watchdog: the run ends with a failure if nothing moves for too long.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("pipelined_prime_sieve verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int choice;
        int len;
        int base;
        int stride;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        steady = 1'b1;

        // Zero in an empty row is stored and then divides nothing.
        send_beat(KIND_NUMBER, 16'd0);
        send_beat(KIND_NUMBER, 16'd5);
        send_beat(KIND_NUMBER, 16'd10);
        send_beat(KIND_NUMBER, 16'hFFFF);
        send_beat(KIND_NUMBER, 16'd7);
        send_beat(KIND_END, 16'hFFFF);
        // One in an empty row swallows the rest of the stream.
        send_beat(KIND_NUMBER, 16'd1);
        send_beat(KIND_NUMBER, 16'd7);
        send_beat(KIND_NUMBER, 16'hFFFF);
        send_beat(KIND_END, 16'd0);
        // Largest value first, then zero is dropped and order is not ascending.
        send_beat(KIND_NUMBER, 16'hFFFF);
        send_beat(KIND_NUMBER, 16'd0);
        send_beat(KIND_NUMBER, 16'd2);
        send_beat(KIND_NUMBER, 16'd4);
        send_beat(KIND_NUMBER, 16'd3);
        send_beat(KIND_NUMBER, 16'h8000);
        send_beat(KIND_NUMBER, 16'd9);
        send_beat(KIND_END, 16'h5555);

        // Random part: mostly proper streams from two, some long enough to fill the row.
        while (beats_sent < TARGET_BEATS)
        begin
            choice = $urandom_range(0, 9);
            steady = ($urandom_range(0, 3) == 0);
            if (choice <= 6)
            begin
                len    = $urandom_range(1, 260);
                stride = (choice == 6) ? $urandom_range(1, 3) : 1;
                for (int i = 0; i < len; i++)
                    send_beat(KIND_NUMBER, 16'(2 + i * stride));
                send_beat(KIND_END, 16'($urandom));
            end
            else if (choice == 7)
            begin
                base = $urandom_range(0, 65000);
                len  = $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    send_beat(KIND_NUMBER, 16'(base + i));
                if ($urandom_range(0, 1) == 1)
                    send_beat(KIND_END, 16'($urandom));
            end
            else if (choice == 8)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_beat(($urandom_range(0, 5) == 0) ? KIND_END : KIND_NUMBER,
                              noise_value());
            end
            else
            begin
                // A stream cut short, carried on into whatever comes next.
                len = $urandom_range(1, 50);
                for (int i = 0; i < len; i++)
                    send_beat(KIND_NUMBER, 16'(2 + i));
            end
        end

        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4 * LATENCY) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("pipelined_prime_sieve verification clean");
        else
            $display("pipelined_prime_sieve verification failed");
        $finish;
    end

endmodule

// ===== pipelined_prime_sieve.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/pipelined_prime_sieve.sv
test/pipelined_prime_sieve_checker.sv
test/pipelined_prime_sieve_tb.sv
